// ----- rtl/countdown_timer_bank_defines.svh -----
// ----------------------------------------------------------------------------
// Countdown timer bank assertion macros
// Shared property wrappers for the timer bank checks, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_BANK_DEFINES_SVH
`define COUNTDOWN_TIMER_BANK_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define CTB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ctb_pkg.sv -----
// ----------------------------------------------------------------------------
// Countdown timer bank package
// Request and result beat types, request and result codes, and defaults.
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int unsigned TIMER_COUNT_DEF = 16;
    localparam int unsigned MAX_SLOTS       = 16;
    localparam logic [15:0] TICK_STEP_RST   = 16'd100;

    localparam logic [2:0] REQ_ALLOC  = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_PAUSE  = 3'd2;
    localparam logic [2:0] REQ_RESUME = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;
    localparam logic [2:0] REQ_QUERY  = 3'd5;

    localparam logic [2:0] KIND_ALLOCATED = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_ACK       = 3'd2;
    localparam logic [2:0] KIND_REMAINING = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;
    localparam logic [2:0] KIND_BAD_INDEX = 3'd6;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  timer_index;
        logic [31:0] timeout;
        logic        periodic;
        logic        has_handler;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  slot_index;
        logic [31:0] remaining_time;
        logic        handler_flag;
        logic        last;
    } t_result;

endpackage

// ----- rtl/countdown_timer_bank.sv -----
// ----------------------------------------------------------------------------
// Countdown timer bank
// Up to sixteen countdown slots with allocate, start, pause, resume, query
// and tick requests, driven by one shared subtract-and-compare unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Allocate, start,
// pause, resume and query finish at once: their single result beat appears
// on the cycle after the request and busy stays low, so these can be issued
// every cycle. A tick walks the allocated slots one per cycle through the
// single 32-bit saturating subtractor, so busy stays high for the sweep and
// the done state; each expiry beat leaves in slot order as its slot is
// visited and a done beat closes the tick. Result beats are shown for exactly
// one cycle with o_strobe and cannot be held off by the receiver. The user must
// load tick_step via i_cfg_we / i_cfg_wdata only while idle (not enforced).
// ----------------------------------------------------------------------------
`include "countdown_timer_bank_defines.svh"

module countdown_timer_bank
    import ctb_pkg::*;
#(
    parameter int unsigned TIMER_COUNT = TIMER_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_strobe,
    output t_result     o_result
);

    localparam int unsigned BANK = (TIMER_COUNT < MAX_SLOTS) ? TIMER_COUNT : MAX_SLOTS;
    localparam int unsigned IW   = (BANK > 1) ? $clog2(BANK) : 1;
    localparam int unsigned CW   = $clog2(BANK + 1);
    localparam int unsigned XW   = (CW > 4) ? CW : 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_slots_used, n_slots_used;
    logic [IW-1:0] r_slot, n_slot;
    logic [15:0]   r_step;
    logic          r_strobe, n_strobe;
    t_result       r_result, n_result;

    logic [31:0] r_time_left  [BANK];
    logic [31:0] r_reload     [BANK];
    logic        r_periodic   [BANK];
    logic        r_paused     [BANK];
    logic        r_running    [BANK];
    logic        r_handler    [BANK];

    logic          accept;
    logic          full;
    logic          idx_ok;
    logic [IW-1:0] idx_t;
    logic [IW-1:0] alloc_slot;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_tl;
    logic [31:0]   tick_sub;
    logic          active;
    logic          expire;
    logic          last_slot;

    assign busy     = (r_state != S_IDLE) || !i_rst_n;
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign full       = (r_slots_used == CW'(BANK));
    assign alloc_slot = r_slots_used[IW-1:0];
    assign idx_t      = i_req.timer_index[IW-1:0];
    assign idx_ok     = XW'(i_req.timer_index) < XW'(r_slots_used);
    assign last_slot  = (CW'(r_slot) + CW'(1)) == r_slots_used;

    // One read port: the tick walker owns it while sweeping, queries otherwise.
    assign rd_addr  = (r_state == S_TICK) ? r_slot : idx_t;
    assign rd_tl    = r_time_left[rd_addr];
    assign tick_sub = (rd_tl > 32'(r_step)) ? (rd_tl - 32'(r_step)) : 32'd0;
    assign active   = r_running[rd_addr] && !r_paused[rd_addr];
    assign expire   = active && (tick_sub == 32'd0);

    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_slots_used = r_slots_used;
        n_strobe     = 1'b0;
        n_result     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type) inside
                        REQ_ALLOC: begin
                            n_strobe             = 1'b1;
                            n_result.last        = 1'b1;
                            if (full) begin
                                n_result.result_kind = KIND_FULL;
                            end else begin
                                n_result.result_kind = KIND_ALLOCATED;
                                n_result.slot_index  = 4'(r_slots_used);
                                n_slots_used         = r_slots_used + CW'(1);
                            end
                        end
                        REQ_TICK: begin
                            n_slot = '0;
                            if (r_slots_used == '0) begin
                                n_strobe             = 1'b1;
                                n_result.result_kind = KIND_TICK_DONE;
                                n_result.last        = 1'b1;
                            end else begin
                                n_state = S_TICK;
                            end
                        end
                        REQ_START, REQ_PAUSE, REQ_RESUME, REQ_QUERY: begin
                            n_strobe            = 1'b1;
                            n_result.last       = 1'b1;
                            n_result.slot_index = i_req.timer_index;
                            if (!idx_ok) begin
                                n_result.result_kind = KIND_BAD_INDEX;
                            end else if (i_req.req_type == REQ_QUERY) begin
                                n_result.result_kind    = KIND_REMAINING;
                                n_result.remaining_time = rd_tl;
                            end else begin
                                n_result.result_kind = KIND_ACK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (expire) begin
                    n_strobe              = 1'b1;
                    n_result.result_kind  = KIND_EXPIRED;
                    n_result.slot_index   = 4'(r_slot);
                    n_result.handler_flag = r_handler[r_slot];
                end
                if (last_slot) begin
                    n_state = S_DONE;
                end else begin
                    n_slot = r_slot + IW'(1);
                end
            end
            S_DONE: begin
                n_strobe             = 1'b1;
                n_result.result_kind = KIND_TICK_DONE;
                n_result.last        = 1'b1;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_slots_used <= '0;
            r_step       <= TICK_STEP_RST;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot       <= n_slot;
            r_slots_used <= n_slots_used;
            r_strobe     <= n_strobe;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // Slot storage: one write per cycle, chosen by the request or the walker.
    always_ff @(posedge i_clk) begin
        if (accept && (i_req.req_type == REQ_ALLOC) && !full) begin
            r_time_left[alloc_slot] <= 32'd0;
            r_reload[alloc_slot]    <= 32'd0;
            r_periodic[alloc_slot]  <= 1'b0;
            r_paused[alloc_slot]    <= 1'b0;
            r_running[alloc_slot]   <= 1'b0;
            r_handler[alloc_slot]   <= 1'b0;
        end
        if (accept && idx_ok && (i_req.req_type == REQ_START)) begin
            r_time_left[idx_t] <= i_req.timeout;
            r_reload[idx_t]    <= i_req.timeout;
            r_periodic[idx_t]  <= i_req.periodic;
            r_paused[idx_t]    <= 1'b0;
            r_running[idx_t]   <= 1'b1;
            r_handler[idx_t]   <= i_req.has_handler;
        end
        if (accept && idx_ok && (i_req.req_type == REQ_PAUSE) && r_running[idx_t]) begin
            r_paused[idx_t] <= 1'b1;
        end
        if (accept && idx_ok && (i_req.req_type == REQ_RESUME) && r_running[idx_t]) begin
            r_paused[idx_t] <= 1'b0;
        end
        if ((r_state == S_TICK) && active) begin
            if (expire) begin
                r_time_left[r_slot] <= r_periodic[r_slot] ? r_reload[r_slot] : 32'd0;
                r_running[r_slot]   <= r_periodic[r_slot];
            end else begin
                r_time_left[r_slot] <= tick_sub;
            end
        end
    end

    `CTB_ASSERT_SAME(a_mid_beat_is_expiry, o_strobe && !o_result.last,
        o_result.result_kind == KIND_EXPIRED, "non-final beat is not an expiry")
    `CTB_ASSERT_SAME(a_count_in_bank, 1'b1, r_slots_used <= CW'(BANK),
        "allocated slot count exceeds bank size")
    `CTB_ASSERT_NEXT(a_tick_progress, start && !busy && (i_req.req_type == REQ_TICK),
        busy || (o_strobe && (o_result.result_kind == KIND_TICK_DONE)),
        "tick neither sweeping nor done")
    `CTB_ASSERT_NEXT(a_command_answers, start && !busy &&
        ((i_req.req_type == REQ_ALLOC) || (i_req.req_type == REQ_START) ||
         (i_req.req_type == REQ_PAUSE) || (i_req.req_type == REQ_RESUME) ||
         (i_req.req_type == REQ_QUERY)),
        o_strobe && o_result.last, "command gave no final beat")

endmodule
